### hw/rtl/servo_position_pi_pwm_defines.svh
// assertion macros for the servo position controller
`ifndef SERVO_POSITION_PI_PWM_DEFINES_SVH
`define SERVO_POSITION_PI_PWM_DEFINES_SVH

`ifndef ASSERT_OFF

// antecedent implies consequent in the same cycle
`define SPP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("servo controller assertion failed");

// antecedent implies consequent in the following cycle
`define SPP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("servo controller assertion failed");

`else

`define SPP_ASSERT_IMPL(label, ante, cons)
`define SPP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### hw/rtl/spp_pkg.sv
`timescale 1ns / 1ps
// shared constants, types and microcode rom of the servo position controller
package spp_pkg;

  localparam int PWM_WINDOW = 1000;
  localparam int PWM_PERIOD = 2000;
  localparam int FULL_SPEED = 1000;
  localparam int MIN_SPAN   = 16;

  localparam int POS_W      = 15;
  localparam int SPEED_W    = 10;
  localparam int DATA_W     = 16;
  localparam int CHAN_W     = 8;
  localparam int OUT_CHAN_W = 3;
  localparam int PROD_W     = POS_W + SPEED_W;
  localparam int DIV_CNT_W  = $clog2(PROD_W + 1);
  localparam int HALF_W     = POS_W - 1;
  localparam int APB_W      = 32;
  localparam int NUM_REGS   = 7;
  localparam int PADDR_W    = $clog2(NUM_REGS * 4);
  localparam int STEP_W     = 4;

  // divide by ten as multiply by reciprocal, exact for all 16-bit magnitudes
  localparam int                RECIP_SHIFT = 19;
  localparam logic [DATA_W-1:0] RECIP_TEN   = 16'hCCCD;
  localparam int                QUOT10_W    = 2 * DATA_W - RECIP_SHIFT;

  localparam logic [POS_W-1:0]  POS_MASK     = 15'h7FFE;
  localparam logic [POS_W-1:0]  MIN_SPAN_V   = POS_W'(MIN_SPAN);
  localparam logic [POS_W-1:0]  FULL_SPEED_V = POS_W'(FULL_SPEED);
  localparam logic [DATA_W-1:0] WINDOW_V     = DATA_W'(PWM_WINDOW);
  localparam logic [DATA_W-1:0] PERIOD_V     = DATA_W'(PWM_PERIOD);

  localparam logic [CHAN_W-1:0] CHAN_FIRST = 8'd3;
  localparam logic [CHAN_W-1:0] CHAN_LAST  = 8'd6;
  localparam logic [OUT_CHAN_W-1:0] OUT_CHAN_FIRST = CHAN_FIRST[OUT_CHAN_W-1:0];
  localparam logic [OUT_CHAN_W-1:0] OUT_CHAN_LAST  = CHAN_LAST[OUT_CHAN_W-1:0];

  typedef enum logic [2:0] {
    REG_LIMIT_A     = 3'd0,
    REG_LIMIT_B     = 3'd1,
    REG_MIN_SPEED   = 3'd2,
    REG_MAX_SPEED   = 3'd3,
    REG_INTEG_LOW   = 3'd4,
    REG_INTEG_HIGH  = 3'd5,
    REG_PWM_CHANNEL = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0]         limit_a;
    logic [POS_W-1:0]         limit_b;
    logic [POS_W-1:0]         min_speed;
    logic [SPEED_W-1:0]       max_speed;
    logic signed [DATA_W-1:0] integ_low;
    logic [POS_W-1:0]         integ_high;
    logic [CHAN_W-1:0]        pwm_channel;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    limit_a:     15'd0,
    limit_b:     15'd0,
    min_speed:   15'd100,
    max_speed:   10'd1000,
    integ_low:   -16'sd800,
    integ_high:  15'd800,
    pwm_channel: 8'd0
  };

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP   = 4'd0,
    OP_LOAD  = 4'd1,
    OP_PREP  = 4'd2,
    OP_MUL   = 4'd3,
    OP_DINIT = 4'd4,
    OP_DSTEP = 4'd5,
    OP_INTEG = 4'd6,
    OP_MAG   = 4'd7,
    OP_RECIP = 4'd8,
    OP_DRIVE = 4'd9,
    OP_PAIR  = 4'd10,
    OP_EMIT  = 4'd11,
    OP_HOME  = 4'd12
  } op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_NEXT     = 3'd0,
    C_ALWAYS   = 3'd1,
    C_NO_START = 3'd2,
    C_BLOCKED  = 3'd3,
    C_EQUAL    = 3'd4,
    C_DIV_MORE = 3'd5,
    C_OUT_BUSY = 3'd6
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT   = 4'd0;
  localparam step_t STEP_PREP   = 4'd1;
  localparam step_t STEP_CHECK  = 4'd2;
  localparam step_t STEP_TARGET = 4'd3;
  localparam step_t STEP_MUL    = 4'd4;
  localparam step_t STEP_DINIT  = 4'd5;
  localparam step_t STEP_DIV    = 4'd6;
  localparam step_t STEP_INTEG  = 4'd7;
  localparam step_t STEP_MAG    = 4'd8;
  localparam step_t STEP_RECIP  = 4'd9;
  localparam step_t STEP_DRIVE  = 4'd10;
  localparam step_t STEP_PAIR   = 4'd11;
  localparam step_t STEP_EMIT   = 4'd12;
  localparam step_t STEP_RET    = 4'd13;
  localparam step_t STEP_HOME   = 4'd14;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic start;
    logic blocked;
    logic equal;
    logic div_last;
    logic emit_stall;
  } status_t;

  function automatic ctl_t ucode_rom(step_t step);
    ctl_t w;
    unique case (step)
      STEP_WAIT:   w = '{OP_LOAD,  C_NO_START, STEP_WAIT};
      STEP_PREP:   w = '{OP_PREP,  C_NEXT,     STEP_WAIT};
      STEP_CHECK:  w = '{OP_NOP,   C_BLOCKED,  STEP_WAIT};
      STEP_TARGET: w = '{OP_NOP,   C_EQUAL,    STEP_HOME};
      STEP_MUL:    w = '{OP_MUL,   C_NEXT,     STEP_WAIT};
      STEP_DINIT:  w = '{OP_DINIT, C_NEXT,     STEP_WAIT};
      STEP_DIV:    w = '{OP_DSTEP, C_DIV_MORE, STEP_DIV};
      STEP_INTEG:  w = '{OP_INTEG, C_NEXT,     STEP_WAIT};
      STEP_MAG:    w = '{OP_MAG,   C_NEXT,     STEP_WAIT};
      STEP_RECIP:  w = '{OP_RECIP, C_NEXT,     STEP_WAIT};
      STEP_DRIVE:  w = '{OP_DRIVE, C_NEXT,     STEP_WAIT};
      STEP_PAIR:   w = '{OP_PAIR,  C_NEXT,     STEP_WAIT};
      STEP_EMIT:   w = '{OP_EMIT,  C_OUT_BUSY, STEP_EMIT};
      STEP_RET:    w = '{OP_NOP,   C_ALWAYS,   STEP_WAIT};
      STEP_HOME:   w = '{OP_HOME,  C_ALWAYS,   STEP_EMIT};
      default:     w = '{OP_NOP,   C_ALWAYS,   STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/spp_seq.sv
`timescale 1ns / 1ps
// microcode sequencer: step counter, control rom and conditional jumps
module spp_seq (
  input  logic             clk,
  input  logic             rst,
  input  spp_pkg::status_t status,
  output spp_pkg::ctl_t    ctl
);
  import spp_pkg::*;

  step_t step;
  step_t step_next;
  logic  take;

  assign ctl = ucode_rom(step);

  always_comb begin
    unique case (ctl.cond)
      C_NEXT:     take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_START: take = !status.start;
      C_BLOCKED:  take = status.blocked;
      C_EQUAL:    take = status.equal;
      C_DIV_MORE: take = !status.div_last;
      C_OUT_BUSY: take = status.emit_stall;
      default:    take = 1'b0;
    endcase
    step_next = take ? ctl.target : STEP_W'(step + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

### hw/rtl/spp_dpath.sv
`timescale 1ns / 1ps
// datapath: operand registers, serial divider, integral, drive sum and output register
module spp_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  spp_pkg::ctl_t                        ctl,
  output spp_pkg::status_t                     status,
  input  spp_pkg::cfg_t                        cfg,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [spp_pkg::POS_W-1:0]            measured_position,
  input  logic [spp_pkg::POS_W-1:0]            target_position,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [spp_pkg::OUT_CHAN_W-1:0]       channel,
  output logic signed [spp_pkg::DATA_W-1:0]    compare_on,
  output logic signed [spp_pkg::DATA_W-1:0]    compare_off
);
  import spp_pkg::*;

  logic [POS_W-1:0]       cur;
  logic [POS_W-1:0]       tgt;
  logic [POS_W-1:0]       span;
  logic [POS_W-1:0]       err;
  logic [PROD_W-1:0]      prod;
  logic [HALF_W-1:0]      dd;
  logic [POS_W-1:0]       rem;
  logic [PROD_W-1:0]      dvd;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [DATA_W-1:0]      integral_sum;
  logic [DATA_W-1:0]      mag;
  logic [2*DATA_W-1:0]    prod10;
  logic [DATA_W-1:0]      n;
  logic [DATA_W-1:0]      on_val;
  logic [DATA_W-1:0]      off_val;

  logic                   normal;
  logic                   down;
  logic                   chan_ok;
  logic                   emit_wr;
  logic [SPEED_W-1:0]     ms;
  logic [HALF_W-1:0]      d_half;
  logic [POS_W-1:0]       dtest;
  logic [DATA_W:0]        rem_sh;
  logic [DATA_W:0]        rem_diff;
  logic                   qbit;
  logic signed [DATA_W:0] err_ext;
  logic signed [DATA_W:0] integ_raw;
  logic signed [DATA_W:0] hi_ext;
  logic signed [DATA_W:0] lo_ext;
  logic signed [DATA_W:0] integ_hi;
  logic signed [DATA_W:0] integ_clamped;
  logic [DATA_W-1:0]      n_mirror;

  assign normal  = cfg.limit_a < cfg.limit_b;
  assign down    = cur > tgt;
  assign chan_ok = (cfg.pwm_channel >= CHAN_FIRST) && (cfg.pwm_channel <= CHAN_LAST);

  assign in_ready = (ctl.op == OP_LOAD) && !rst;

  assign status.start      = in_valid && in_ready;
  assign status.blocked    = (cfg.limit_a == cfg.limit_b) || (span < MIN_SPAN_V);
  assign status.equal      = cur == tgt;
  assign status.div_last   = div_cnt == DIV_CNT_W'(1);
  assign status.emit_stall = chan_ok && out_valid && !out_ready;

  assign emit_wr = (ctl.op == OP_EMIT) && chan_ok && !status.emit_stall;

  // proportional gain numerator, capped at full speed
  assign ms = (POS_W'(cfg.max_speed) > FULL_SPEED_V) ? FULL_SPEED_V[SPEED_W-1:0]
                                                      : cfg.max_speed;

  // derivative term: tested value is the measured position going down, the error going up
  assign d_half = cfg.min_speed[POS_W-1:1];
  assign dtest  = down ? cur : err;

  // one restoring quotient bit per cycle
  assign rem_sh   = {1'b0, rem, dvd[PROD_W-1]};
  assign rem_diff = rem_sh - {2'b00, span};
  assign qbit     = rem_sh >= {2'b00, span};

  // integral update and clamp, upper bound first
  assign err_ext       = signed'({2'b00, err});
  assign integ_raw     = signed'({integral_sum[DATA_W-1], integral_sum})
                         + (down ? err_ext : -err_ext);
  assign hi_ext        = signed'({2'b00, cfg.integ_high});
  assign lo_ext        = signed'({cfg.integ_low[DATA_W-1], cfg.integ_low});
  assign integ_hi      = (integ_raw > hi_ext) ? hi_ext : integ_raw;
  assign integ_clamped = (integ_hi < lo_ext) ? lo_ext : integ_hi;

  assign n_mirror = ($signed(n) > $signed(WINDOW_V)) ? DATA_W'(n - WINDOW_V) : n;

  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
    end else if (ctl.op == OP_INTEG) begin
      integral_sum <= integ_clamped[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        if (status.start) begin
          cur <= measured_position & POS_MASK;
          tgt <= target_position & POS_MASK;
        end
      end
      OP_PREP: begin
        span <= normal ? POS_W'(cfg.limit_b - cfg.limit_a) : POS_W'(cfg.limit_a - cfg.limit_b);
        err  <= down ? POS_W'(cur - tgt) : POS_W'(tgt - cur);
      end
      OP_MUL: begin
        prod <= PROD_W'(err) * PROD_W'(ms);
        dd   <= (dtest > POS_W'(d_half)) ? d_half : '0;
      end
      OP_DINIT: begin
        rem     <= '0;
        dvd     <= prod;
        div_cnt <= DIV_CNT_W'(PROD_W);
      end
      OP_DSTEP: begin
        rem     <= qbit ? rem_diff[POS_W-1:0] : rem_sh[POS_W-1:0];
        dvd     <= {dvd[PROD_W-2:0], qbit};
        div_cnt <= DIV_CNT_W'(div_cnt - 1'b1);
      end
      OP_MAG: begin
        mag <= integral_sum[DATA_W-1] ? DATA_W'(-integral_sum) : integral_sum;
      end
      OP_RECIP: begin
        prod10 <= (2*DATA_W)'(mag) * (2*DATA_W)'(RECIP_TEN);
      end
      OP_DRIVE: begin
        n <= DATA_W'(dvd[DATA_W-1:0] + DATA_W'(prod10[2*DATA_W-1:RECIP_SHIFT])
             - DATA_W'(dd));
      end
      OP_PAIR: begin
        if (down == normal) begin
          on_val  <= n;
          off_val <= DATA_W'(n + PERIOD_V);
        end else begin
          on_val  <= DATA_W'(WINDOW_V - n_mirror);
          off_val <= DATA_W'(PERIOD_V - n_mirror);
        end
      end
      OP_HOME: begin
        on_val  <= '0;
        off_val <= PERIOD_V;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_wr) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_wr) begin
      channel     <= cfg.pwm_channel[OUT_CHAN_W-1:0];
      compare_on  <= $signed(on_val);
      compare_off <= $signed(off_val);
    end
  end

endmodule

### hw/rtl/servo_position_pi_pwm.sv
`timescale 1ns / 1ps
// top level of the servo position controller: register port, sequencer and datapath
//
//  channel   signals                               transaction
//  --------  ------------------------------------  -------------------------------------
//  input     in_valid / in_ready                   measured_position, target_position
//  output    out_valid / out_ready                 channel, compare_on, compare_off
//  config    psel penable pwrite paddr pwdata      one register write or read
//
// an item with a result goes from acceptance through the quotient loop of the serial
// divider behind the proportional term to its emit step before the next in_ready
// blocked items go back to wait after the check; at the target the home step runs
// reset is synchronous and active high; it resets the registers, the integral and
// the step counter; the result register holds one transaction, and the program
// waits at its emit step while that register is full and not being taken
`include "servo_position_pi_pwm_defines.svh"

module servo_position_pi_pwm (
  input  logic                                 clk,
  input  logic                                 rst,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [spp_pkg::PADDR_W-1:0]          paddr,
  input  logic [spp_pkg::APB_W-1:0]            pwdata,
  output logic [spp_pkg::APB_W-1:0]            prdata,
  output logic                                 pready,
  // position samples
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [spp_pkg::POS_W-1:0]            measured_position,
  input  logic [spp_pkg::POS_W-1:0]            target_position,
  // compare values
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [spp_pkg::OUT_CHAN_W-1:0]       channel,
  output logic signed [spp_pkg::DATA_W-1:0]    compare_on,
  output logic signed [spp_pkg::DATA_W-1:0]    compare_off
);
  import spp_pkg::*;

  cfg_t     cfg;
  ctl_t     ctl;
  status_t  status;
  reg_idx_t reg_idx;
  logic     wr_en;

  // no wait states on the register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register writes; an address past the last register is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LIMIT_A:     cfg.limit_a     <= pwdata[POS_W-1:0];
        REG_LIMIT_B:     cfg.limit_b     <= pwdata[POS_W-1:0];
        REG_MIN_SPEED:   cfg.min_speed   <= pwdata[POS_W-1:0];
        REG_MAX_SPEED:   cfg.max_speed   <= pwdata[SPEED_W-1:0];
        REG_INTEG_LOW:   cfg.integ_low   <= $signed(pwdata[DATA_W-1:0]);
        REG_INTEG_HIGH:  cfg.integ_high  <= pwdata[POS_W-1:0];
        REG_PWM_CHANNEL: cfg.pwm_channel <= pwdata[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback, integ_low sign extended
  always_comb begin
    unique case (reg_idx)
      REG_LIMIT_A:     prdata = APB_W'(cfg.limit_a);
      REG_LIMIT_B:     prdata = APB_W'(cfg.limit_b);
      REG_MIN_SPEED:   prdata = APB_W'(cfg.min_speed);
      REG_MAX_SPEED:   prdata = APB_W'(cfg.max_speed);
      REG_INTEG_LOW:   prdata = APB_W'(cfg.integ_low);
      REG_INTEG_HIGH:  prdata = APB_W'(cfg.integ_high);
      REG_PWM_CHANNEL: prdata = APB_W'(cfg.pwm_channel);
      default:         prdata = '0;
    endcase
  end

  // control program
  spp_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  // arithmetic and result register
  spp_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .ctl               (ctl),
    .status            (status),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .measured_position (measured_position),
    .target_position   (target_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .channel           (channel),
    .compare_on        (compare_on),
    .compare_off       (compare_off)
  );

  // a result only ever goes to one of the four motor channels
  `SPP_ASSERT_IMPL(a_out_chan_range, out_valid, (channel >= OUT_CHAN_FIRST) && (channel <= OUT_CHAN_LAST))

  // one item at a time: the program leaves its wait step right after a transaction
  `SPP_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready)

  // blocked limits send the program straight back to wait for the next sample
  `SPP_ASSERT_NEXT(a_blocked_return, (ctl.cond == C_BLOCKED) && status.blocked, in_ready)

endmodule

### tb/servo_position_pi_pwm_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the servo position controller against a cycle-free local model

module servo_position_pi_pwm_tb;
  import spp_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int RESET_CYCLES  = 11;
  // long enough for any silent item still in flight to finish
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 4000;
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_SAMPLES = 50;
  // first byte address past the register file
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(NUM_REGS * 4);

  typedef struct packed {
    logic [POS_W-1:0] meas;
    logic [POS_W-1:0] targ;
  } sample_t;

  typedef struct packed {
    logic [OUT_CHAN_W-1:0]    chan;
    logic signed [DATA_W-1:0] on_time;
    logic signed [DATA_W-1:0] off_time;
  } compare_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [PADDR_W-1:0]       paddr   = '0;
  logic [APB_W-1:0]         pwdata  = '0;
  logic [APB_W-1:0]         prdata;
  logic                     pready;

  logic                     in_valid          = 1'b0;
  logic                     in_ready;
  logic [POS_W-1:0]         measured_position = '0;
  logic [POS_W-1:0]         target_position   = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [OUT_CHAN_W-1:0]    channel;
  logic signed [DATA_W-1:0] compare_on;
  logic signed [DATA_W-1:0] compare_off;

  // shadow copy of the register file, at reset values
  logic [POS_W-1:0]         sh_limit_a    = 15'd0;
  logic [POS_W-1:0]         sh_limit_b    = 15'd0;
  logic [POS_W-1:0]         sh_min_speed  = 15'd100;
  logic [SPEED_W-1:0]       sh_max_speed  = 10'd1000;
  logic signed [DATA_W-1:0] sh_integ_low  = -16'sd800;
  logic [POS_W-1:0]         sh_integ_high = 15'd800;
  logic [CHAN_W-1:0]        sh_channel    = 8'd0;
  // integral accumulator of the model, always within 16-bit signed range
  int                       integ_acc     = 0;

  sample_t  pending_samples[$];
  compare_t expected_compares[$];

  // per-phase idling, in percent of cycles
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  int n_samples    = 0;
  int n_results    = 0;
  int n_cfg_writes = 0;
  int n_phases     = 0;
  int error_count  = 0;
  int stall_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  servo_position_pi_pwm DUT (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .measured_position (measured_position),
    .target_position   (target_position),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .channel           (channel),
    .compare_on        (compare_on),
    .compare_off       (compare_off)
  );

  // compare pair for one position sample; updates the integral as the block does,
  // returns 0 where the block stays silent
  function automatic bit compute_compare(input sample_t smp, output compare_t res);
    int cur, tgt, a, b, span, err, ms, p, s, lo, hi, mag, half, dtest, n, on_t, off_t;
    logic [DATA_W-1:0] wrapped;
    bit normal, down;
    res = '0;
    // bit 0 of both positions is ignored
    cur = {smp.meas[POS_W-1:1], 1'b0};
    tgt = {smp.targ[POS_W-1:1], 1'b0};
    a = sh_limit_a;
    b = sh_limit_b;
    // equal limits or a span below the minimum: blocked, state untouched
    if (a == b) return 0;
    normal = a < b;
    span = normal ? b - a : a - b;
    if (span < MIN_SPAN) return 0;
    if (cur == tgt) begin
      // at target: home pair, integral untouched
      on_t  = 0;
      off_t = PWM_PERIOD;
    end else begin
      down = cur > tgt;
      err  = down ? cur - tgt : tgt - cur;
      ms   = (sh_max_speed > FULL_SPEED) ? FULL_SPEED : sh_max_speed;
      p    = ((err * ms) / span) & 16'hFFFF;
      s    = integ_acc + (down ? err : -err);
      hi   = sh_integ_high;
      lo   = sh_integ_low;
      // upper clamp first, so crossed clamps settle on the lower one
      if (s > hi) s = hi;
      if (s < lo) s = lo;
      integ_acc = s;
      mag   = (s < 0) ? -s : s;
      half  = sh_min_speed >> 1;
      // derivative test: measured position moving down, error moving up
      dtest = down ? cur : err;
      wrapped = DATA_W'(p + mag / 10 - ((dtest > half) ? half : 0));
      n = $signed(wrapped);
      if (down == normal) begin
        on_t  = n;
        off_t = n + PWM_PERIOD;
      end else begin
        if (n > PWM_WINDOW) n = n - PWM_WINDOW;
        on_t  = PWM_WINDOW - n;
        off_t = PWM_PERIOD - n;
      end
    end
    // out-of-range channel: integral already moved, but nothing comes out
    if (sh_channel < CHAN_FIRST || sh_channel > CHAN_LAST) return 0;
    res.chan     = sh_channel[OUT_CHAN_W-1:0];
    res.on_time  = DATA_W'(on_t);
    res.off_time = DATA_W'(off_t);
    return 1;
  endfunction

  // setup cycle, access cycle; the register takes the data at the edge ending access
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    n_cfg_writes++;
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [APB_W-1:0] value);
    logic [APB_W-1:0] mask, data;
    case (idx)
      REG_MAX_SPEED:   mask = 32'h0000_03FF;
      REG_INTEG_LOW:   mask = 32'h0000_FFFF;
      REG_PWM_CHANNEL: mask = 32'h0000_00FF;
      default:         mask = 32'h0000_7FFF;
    endcase
    // half the writes carry junk above the register width, which must be dropped
    data = $urandom_range(1) ? ((value & mask) | ($urandom() & ~mask)) : value;
    case (idx)
      REG_LIMIT_A:     sh_limit_a    = data[POS_W-1:0];
      REG_LIMIT_B:     sh_limit_b    = data[POS_W-1:0];
      REG_MIN_SPEED:   sh_min_speed  = data[POS_W-1:0];
      REG_MAX_SPEED:   sh_max_speed  = data[SPEED_W-1:0];
      REG_INTEG_LOW:   sh_integ_low  = data[DATA_W-1:0];
      REG_INTEG_HIGH:  sh_integ_high = data[POS_W-1:0];
      REG_PWM_CHANNEL: sh_channel    = data[CHAN_W-1:0];
      default: ;
    endcase
    apb_write(PADDR_W'(4 * int'(idx)), data);
  endtask

  task automatic push_sample(input int meas, input int targ);
    sample_t smp;
    smp.meas = POS_W'(meas);
    smp.targ = POS_W'(targ);
    pending_samples.push_back(smp);
  endtask

  // all samples taken and all results seen, then room for a silent item to finish
  task automatic wait_for_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_compares.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    n_phases++;
  endtask

  // sample driver: predicts at acceptance, then loads the next sample or idles
  always @(posedge clk) begin
    sample_t  took, nxt;
    compare_t want;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        n_samples++;
        took.meas = measured_position;
        took.targ = target_position;
        if (compute_compare(took, want)) expected_compares.push_back(want);
      end
      // payload only moves when the slot is empty or just emptied
      if (!in_valid || in_ready) begin
        if (pending_samples.size() != 0 && !($urandom_range(99) < sender_idle_pct)) begin
          nxt = pending_samples.pop_front();
          in_valid          <= 1'b1;
          measured_position <= nxt.meas;
          target_position   <= nxt.targ;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: each transaction against the oldest expected compare pair
  always @(posedge clk) begin
    compare_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_compares.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result chan=%0d on=%0d off=%0d",
                   $time, channel, compare_on, compare_off);
        end else begin
          want = expected_compares.pop_front();
          n_results++;
          if (channel !== want.chan || compare_on !== want.on_time ||
              compare_off !== want.off_time) begin
            error_count++;
            $display("%0t: mismatch expected ch=%0d on=%0d off=%0d actual ch=%0d on=%0d off=%0d",
                     $time, want.chan, want.on_time, want.off_time,
                     channel, compare_on, compare_off);
          end
        end
      end
      out_ready <= !($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction on any port
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (psel && penable && pwrite)) begin
      stall_cycles <= 0;
    end else if (stall_cycles < STALL_LIMIT) begin
      stall_cycles <= stall_cycles + 1;
    end else begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int a, b, kind, diff, m, t;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // reset limits are equal: blocked, nothing comes out
    push_sample(6000, 5000);
    push_sample(100, 200);
    wait_for_idle();

    // normal orientation with reset gains; a write past the register file is ignored
    cfg_write(REG_LIMIT_A, 1000);
    cfg_write(REG_LIMIT_B, 9000);
    cfg_write(REG_PWM_CHANNEL, 3);
    apb_write(UNUSED_ADDR, 32'hFFFF_FFFF);
    push_sample(5000, 5000);
    push_sample(5000, 5001);      // equal once bit 0 is dropped
    push_sample(6000, 5000);
    push_sample(5000, 6000);
    push_sample(32767, 0);        // drive integral into the upper clamp
    push_sample(32767, 0);
    push_sample(32767, 32766);
    push_sample(0, 32767);        // and down into the lower clamp
    push_sample(0, 32767);
    push_sample(0, 32767);
    push_sample(0, 0);
    push_sample(5000, 5002);      // small error, derivative test fails
    push_sample(2, 0);            // low measured position, derivative test fails
    push_sample(0, 32766);
    wait_for_idle();

    // inverted, smallest usable span, clamped speed, crossed integral clamps
    cfg_write(REG_LIMIT_A, 9016);
    cfg_write(REG_LIMIT_B, 9000);
    cfg_write(REG_MAX_SPEED, 1023);
    cfg_write(REG_MIN_SPEED, 32767);
    cfg_write(REG_INTEG_LOW, 300);
    cfg_write(REG_INTEG_HIGH, 0);
    cfg_write(REG_PWM_CHANNEL, 6);
    push_sample(32766, 0);        // proportional term wraps
    push_sample(0, 32766);
    push_sample(20, 10);
    push_sample(10, 20);
    wait_for_idle();

    // span one below the minimum: blocked
    cfg_write(REG_LIMIT_B, 9001);
    push_sample(300, 200);
    wait_for_idle();

    // full-scale limits with channel out of range: integral still moves
    cfg_write(REG_LIMIT_A, 0);
    cfg_write(REG_LIMIT_B, 32767);
    cfg_write(REG_PWM_CHANNEL, 255);
    cfg_write(REG_INTEG_LOW, 32'hFFFF_8000);
    cfg_write(REG_INTEG_HIGH, 32767);
    cfg_write(REG_MIN_SPEED, 0);
    push_sample(9000, 1000);
    push_sample(9000, 1000);
    wait_for_idle();

    // back on a valid channel with zero speed, integral carried over
    cfg_write(REG_PWM_CHANNEL, 5);
    cfg_write(REG_MAX_SPEED, 0);
    push_sample(1000, 9000);
    push_sample(32766, 0);
    wait_for_idle();

    // random phases, each with fresh settings and its own idling pattern
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      @(posedge clk);
      case (ph % 4)
        0: begin sender_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin sender_idle_pct <= 87; recv_stall_pct <= 0;  end
        2: begin sender_idle_pct <= 0;  recv_stall_pct <= 87; end
        default: begin sender_idle_pct <= 30; recv_stall_pct <= 30; end
      endcase

      // mostly wide spans, sometimes near or at the blocking boundary
      a = $urandom_range(0, 32767);
      kind = $urandom_range(0, 9);
      if (kind == 0) b = a;
      else if (kind == 1) begin
        diff = $urandom_range(0, 31);
        b = (a > 16383) ? a - diff : a + diff;
      end else b = $urandom_range(0, 32767);
      cfg_write(REG_LIMIT_A, a);
      cfg_write(REG_LIMIT_B, b);
      cfg_write(REG_MIN_SPEED,
                $urandom_range(1) ? $urandom_range(0, 32767) : $urandom_range(0, 200));
      cfg_write(REG_MAX_SPEED, $urandom_range(0, 1023));
      // now and then any 16-bit lower clamp, which may cross the upper one
      cfg_write(REG_INTEG_LOW,
                (kind == 2) ? $urandom() : -int'($urandom_range(0, 32768)));
      cfg_write(REG_INTEG_HIGH,
                $urandom_range(1) ? $urandom_range(0, 32767) : $urandom_range(0, 2000));
      cfg_write(REG_PWM_CHANNEL,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(3, 6));

      for (int k = 0; k < PHASE_SAMPLES; k++) begin
        m = $urandom_range(0, 32767);
        kind = $urandom_range(0, 9);
        if (kind == 0) t = m ^ $urandom_range(0, 1);
        else if (kind <= 3) begin
          diff = $urandom_range(0, 64);
          t = (m > 16383) ? m - diff : m + diff;
        end else t = $urandom_range(0, 32767);
        push_sample(m, t);
      end
      wait_for_idle();
    end

    if (expected_compares.size() != 0) begin
      error_count += expected_compares.size();
      $display("%0t: %0d expected results never arrived", $time, expected_compares.size());
    end
    $display("run covered %0d position samples in %0d phases with %0d register writes",
             n_samples, n_phases, n_cfg_writes);
    $display("checked %0d compare results, %0d failures", n_results, error_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
